/* rtl/core/lru_page_list_macros.svh */
// ----------------------------------------------------------------------------
// LRU page list assertion macros
// Shared concurrent assertion forms used by the page list RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_LIST_MACROS_SVH
`define LRU_PAGE_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_page_list assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_page_list assertion failed");

`endif

/* rtl/core/lru_pl_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page list package
// Types, codes and defaults shared by the page list cells and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru_pl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned PAGE_W = 32;
  localparam int unsigned OCC_W = 7;

  typedef enum logic [1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_INSERT     = 2'd1,
    CMD_EVICT_LRU  = 2'd2,
    CMD_EVICT_PAGE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_DUP  = 2'd3
  } status_e;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              ref_b;
    logic              dirty;
  } entry_t;

  typedef struct packed {
    logic              cmp_en;
    logic              cmp_head_only;
    logic [PAGE_W-1:0] key;
    logic              ins_en;
    logic              rem_en;
    entry_t            ins_entry;
  } cell_ctrl_t;

endpackage

/* rtl/core/lru_pl_cell.sv */
// ----------------------------------------------------------------------------
// LRU page list cell
// One slot of the recency chain: holds an entry, compares it against the
// key and takes the new entry or its newer neighbor's entry on a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_pl_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lru_pl_pkg::cell_ctrl_t ctrl_i,
  input  logic                   head_i,
  input  logic                   prev_valid_i,
  input  logic                   shift_i,
  input  logic                   next_valid_i,
  input  lru_pl_pkg::entry_t     next_entry_i,
  output logic                   valid_o,
  output lru_pl_pkg::entry_t     entry_o,
  output logic                   match_o
);

  logic               valid_q, valid_d;
  logic               match_q, match_d;
  lru_pl_pkg::entry_t entry_q, entry_d;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_q & (ctrl_i.cmp_head_only ? head_i : (entry_q.page == ctrl_i.key));
    end
    if (ctrl_i.ins_en && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      entry_d = ctrl_i.ins_entry;
    end else if (ctrl_i.rem_en && shift_i) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

/* rtl/core/lru_page_list.sv */
// Flow: a command word is taken in the idle state, the cell chain compares it in the
// compare state, and the select, prefix and commit state registers its result word.
// No new command word is taken until the current one has left the commit state.
// A stalled result word holds the next command in its commit cycle until it is taken.
// Reset: asynchronous active low; the list comes up empty with no result pending.
// ----------------------------------------------------------------------------
// LRU page list top level
// Recency-ordered page list with associative lookup built from a chain of
// slot cells; slot zero holds the least recent entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_page_list_macros.svh"

module lru_page_list #(
  parameter int unsigned CAPACITY = lru_pl_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [lru_pl_pkg::PAGE_W-1:0] page_i,
  input  logic                          ref_bit_i,
  input  logic                          dirty_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [lru_pl_pkg::PAGE_W-1:0] page_out_o,
  output logic                          ref_out_o,
  output logic                          dirty_out_o,
  output logic [1:0]                    status_o,
  output logic [lru_pl_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LVL = $clog2(CAPACITY);
  localparam int unsigned ENT_W = $bits(lru_pl_pkg::entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_e;

  state_e                        state_q;
  logic [CNT_W-1:0]              count_q;
  logic                          out_valid_q;
  logic                          hit_q;
  logic [lru_pl_pkg::PAGE_W-1:0] page_out_q;
  logic                          ref_out_q;
  logic                          dirty_out_q;
  lru_pl_pkg::status_e           status_q;
  logic [lru_pl_pkg::OCC_W-1:0]  occ_q;

  lru_pl_pkg::cmd_e              cmd_q;
  logic [lru_pl_pkg::PAGE_W-1:0] page_q;
  logic                          ref_q;
  logic                          dirty_q;

  logic                          in_fire;
  logic                          exec_fire;
  logic                          any_match;
  logic                          full;
  logic                          ins_ok;
  logic                          rem_ok;
  logic                          res_hit;
  logic [CNT_W-1:0]              count_d;
  lru_pl_pkg::status_e           status_d;
  lru_pl_pkg::entry_t            sel_entry;
  logic [ENT_W-1:0]              sel_bits;
  lru_pl_pkg::cell_ctrl_t        ctrl;

  logic [CAPACITY-1:0]           valid_vec;
  logic [CAPACITY-1:0]           match_vec;
  logic [CAPACITY-1:0]           pfx;
  logic [CAPACITY-1:0]           pfx_tmp;
  lru_pl_pkg::entry_t            cell_entry [CAPACITY];

  assign in_fire   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_bits = sel_bits | (cell_entry[i] & {ENT_W{match_vec[i]}});
    end
    sel_entry = lru_pl_pkg::entry_t'(sel_bits);
  end

  always_comb begin
    pfx = match_vec;
    pfx_tmp = match_vec;
    for (int l = 0; l < LVL; l++) begin
      pfx_tmp = pfx;
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pfx[i] = pfx_tmp[i] | pfx_tmp[i - (1 << l)];
        end
      end
    end
  end

  assign any_match = |match_vec;
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign ins_ok    = (cmd_q == lru_pl_pkg::CMD_INSERT) && !any_match && !full;
  assign rem_ok    = ((cmd_q == lru_pl_pkg::CMD_EVICT_LRU) ||
                      (cmd_q == lru_pl_pkg::CMD_EVICT_PAGE)) && any_match;
  assign res_hit   = (cmd_q != lru_pl_pkg::CMD_INSERT) && any_match;

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd_q)
      lru_pl_pkg::CMD_INSERT: begin
        if (any_match) begin
          status_d = lru_pl_pkg::ST_DUP;
        end else if (full) begin
          status_d = lru_pl_pkg::ST_FULL;
        end else begin
          status_d = lru_pl_pkg::ST_OK;
        end
      end
      default: begin
        status_d = any_match ? lru_pl_pkg::ST_OK : lru_pl_pkg::ST_MISS;
      end
    endcase
  end

  always_comb begin
    ctrl.cmp_en          = (state_q == S_CMP);
    ctrl.cmp_head_only   = (cmd_q == lru_pl_pkg::CMD_EVICT_LRU);
    ctrl.key             = page_q;
    ctrl.ins_en          = exec_fire && ins_ok;
    ctrl.rem_en          = exec_fire && rem_ok;
    ctrl.ins_entry.page  = page_q;
    ctrl.ins_entry.ref_b = ref_q;
    ctrl.ins_entry.dirty = dirty_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               prev_valid;
    logic               next_valid;
    lru_pl_pkg::entry_t next_entry;

    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = valid_vec[g+1];
      assign next_entry = cell_entry[g+1];
    end

    lru_pl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .head_i       (g == 0),
      .prev_valid_i (prev_valid),
      .shift_i      (pfx[g]),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .valid_o      (valid_vec[g]),
      .entry_o      (cell_entry[g]),
      .match_o      (match_vec[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= lru_pl_pkg::cmd_e'(command_i);
      page_q  <= page_i;
      ref_q   <= ref_bit_i;
      dirty_q <= dirty_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      page_out_q  <= '0;
      ref_out_q   <= 1'b0;
      dirty_out_q <= 1'b0;
      status_q    <= lru_pl_pkg::ST_OK;
      occ_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        hit_q       <= res_hit;
        page_out_q  <= res_hit ? sel_entry.page : '0;
        ref_out_q   <= res_hit && sel_entry.ref_b;
        dirty_out_q <= res_hit && sel_entry.dirty;
        status_q    <= status_d;
        occ_q       <= lru_pl_pkg::OCC_W'(count_d);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign page_out_o  = page_out_q;
  assign ref_out_o   = ref_out_q;
  assign dirty_out_o = dirty_out_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  `LPL_ASSERT_IMP(a_match_unique, clk_i, rst_ni, state_q == S_EXEC, $onehot0(match_vec))
  `LPL_ASSERT_IMP(a_count_tracks_valid, clk_i, rst_ni, 1'b1, $countones(valid_vec) == count_q)
  `LPL_ASSERT_NXT(a_remove_decrements, clk_i, rst_ni, exec_fire && rem_ok, count_q == $past(count_q) - CNT_W'(1))
  `LPL_ASSERT_IMP(a_no_insert_when_full, clk_i, rst_ni, full, !ins_ok)

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page list testbench
// Sends command words to the page list under random sender gaps and receiver
// stalls, predicts every result word from a local copy of the recency list,
// and compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LIST_DEPTH = lru_pl_pkg::CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned FIELD_W = lru_pl_pkg::PAGE_W;

  typedef struct packed {
    logic                          hit;
    logic [lru_pl_pkg::PAGE_W-1:0] page;
    logic                          ref_b;
    logic                          dirty;
    lru_pl_pkg::status_e           status;
    logic [lru_pl_pkg::OCC_W-1:0]  occ;
  } list_outcome_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  lru_pl_pkg::cmd_e              command;
  logic [lru_pl_pkg::PAGE_W-1:0] page;
  logic                          ref_bit;
  logic                          dirty_in;
  logic                          out_valid;
  logic                          out_stall;
  logic                          hit;
  logic [lru_pl_pkg::PAGE_W-1:0] page_out;
  logic                          ref_out;
  logic                          dirty_out;
  logic [1:0]                    status;
  logic [lru_pl_pkg::OCC_W-1:0]  occupancy;

  logic [lru_pl_pkg::PAGE_W-1:0] held_page [LIST_DEPTH];
  logic                          held_ref [LIST_DEPTH];
  logic                          held_dirty [LIST_DEPTH];
  int                            held_count;

  list_outcome_t     outcome_q [$];
  list_outcome_t     want_outcome;
  int unsigned       error_count;
  int unsigned       cycle_count = 0;
  bit                gaps_on;
  int unsigned       burst_left;
  bit                hold_req;
  int unsigned       hold_len;

  lru_page_list #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .page_i      (page),
    .ref_bit_i   (ref_bit),
    .dirty_in_i  (dirty_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .hit_o       (hit),
    .page_out_o  (page_out),
    .ref_out_o   (ref_out),
    .dirty_out_o (dirty_out),
    .status_o    (status),
    .occupancy_o (occupancy)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int find_held(logic [lru_pl_pkg::PAGE_W-1:0] pg);
    for (int i = 0; i < held_count; i++) begin
      if (held_page[i] == pg) return i;
    end
    return -1;
  endfunction

  function automatic list_outcome_t compute_list_outcome(lru_pl_pkg::cmd_e cmd,
                                                         logic [lru_pl_pkg::PAGE_W-1:0] pg,
                                                         logic rb, logic db);
    list_outcome_t res;
    int            idx;
    res = '0;
    res.status = lru_pl_pkg::ST_OK;
    case (cmd)
      lru_pl_pkg::CMD_LOOKUP: begin
        idx = find_held(pg);
        if (idx >= 0) begin
          res.hit = 1'b1;
          res.page = held_page[idx];
          res.ref_b = held_ref[idx];
          res.dirty = held_dirty[idx];
        end else begin
          res.status = lru_pl_pkg::ST_MISS;
        end
      end
      lru_pl_pkg::CMD_INSERT: begin
        if (find_held(pg) >= 0) begin
          res.status = lru_pl_pkg::ST_DUP;
        end else if (held_count >= LIST_DEPTH) begin
          res.status = lru_pl_pkg::ST_FULL;
        end else begin
          held_page[held_count] = pg;
          held_ref[held_count] = rb;
          held_dirty[held_count] = db;
          held_count++;
        end
      end
      default: begin
        if (cmd == lru_pl_pkg::CMD_EVICT_LRU) idx = (held_count > 0) ? 0 : -1;
        else idx = find_held(pg);
        if (idx >= 0) begin
          res.hit = 1'b1;
          res.page = held_page[idx];
          res.ref_b = held_ref[idx];
          res.dirty = held_dirty[idx];
          for (int i = idx; i + 1 < held_count; i++) begin
            held_page[i] = held_page[i + 1];
            held_ref[i] = held_ref[i + 1];
            held_dirty[i] = held_dirty[i + 1];
          end
          held_count--;
        end else begin
          res.status = lru_pl_pkg::ST_MISS;
        end
      end
    endcase
    res.occ = held_count[lru_pl_pkg::OCC_W-1:0];
    return res;
  endfunction

  function automatic logic [lru_pl_pkg::PAGE_W-1:0] fresh_page();
    logic [lru_pl_pkg::PAGE_W-1:0] pg;
    do pg = $urandom; while (find_held(pg) >= 0);
    return pg;
  endfunction

  function automatic logic [lru_pl_pkg::PAGE_W-1:0] pick_page(int unsigned held_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (held_count > 0 && roll < held_pct) return held_page[$urandom_range(0, held_count - 1)];
    if (roll < held_pct + 10) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  task automatic send_word(lru_pl_pkg::cmd_e cmd, logic [lru_pl_pkg::PAGE_W-1:0] pg,
                           logic rb, logic db);
    in_valid <= 1'b1;
    command <= cmd;
    page <= pg;
    ref_bit <= rb;
    dirty_in <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    outcome_q.push_back(compute_list_outcome(cmd, pg, rb, db));
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        error_count++;
        $display("%0t unexpected result word: expected none actual page %h status %0d",
                 $time, page_out, status);
      end else begin
        want_outcome = outcome_q.pop_front();
        report_field("hit", FIELD_W'(want_outcome.hit), FIELD_W'(hit));
        report_field("page_out", want_outcome.page, page_out);
        report_field("ref_out", FIELD_W'(want_outcome.ref_b), FIELD_W'(ref_out));
        report_field("dirty_out", FIELD_W'(want_outcome.dirty), FIELD_W'(dirty_out));
        report_field("status", FIELD_W'(want_outcome.status), FIELD_W'(status));
        report_field("occupancy", FIELD_W'(want_outcome.occ), FIELD_W'(occupancy));
      end
    end
  end

  initial begin : receiver_stall
    int unsigned mode;
    int unsigned seg;
    int unsigned tick;
    out_stall = 1'b0;
    tick = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(20, 200);
      repeat (seg) begin
        if (hold_req) begin
          hold_req = 1'b0;
          repeat (hold_len) begin
            out_stall <= 1'b1;
            @(posedge clk);
          end
        end
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 5) < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic test_empty_list();
    send_word(lru_pl_pkg::CMD_EVICT_LRU, 32'h0000_0000, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_PAGE, 32'h0000_0000, 1'b1, 1'b1);
    send_word(lru_pl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1);
  endtask

  task automatic test_insert_lookup_edges();
    send_word(lru_pl_pkg::CMD_INSERT, 32'h0000_0000, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(lru_pl_pkg::CMD_INSERT, 32'hA5A5_5A5A, 1'b1, 1'b0);
    send_word(lru_pl_pkg::CMD_INSERT, 32'h5A5A_A5A5, 1'b0, 1'b1);
    send_word(lru_pl_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, 1'b1);
    send_word(lru_pl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_LOOKUP, 32'h0000_0001, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 1'b1);
    send_word(lru_pl_pkg::CMD_EVICT_PAGE, 32'h0000_0007, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_PAGE, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_LRU, 32'h1234_5678, 1'b1, 1'b0);
    send_word(lru_pl_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_PAGE, 32'h5A5A_A5A5, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_LRU, 32'h0000_0000, 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_LRU, 32'h0000_0000, 1'b0, 1'b0);
  endtask

  task automatic test_fill_to_capacity();
    logic [lru_pl_pkg::PAGE_W-1:0] pg;
    gaps_on = 1'b1;
    while (held_count < LIST_DEPTH)
      send_word(lru_pl_pkg::CMD_INSERT, fresh_page(), rand_bit(), rand_bit());
    send_word(lru_pl_pkg::CMD_INSERT, fresh_page(), 1'b1, 1'b1);
    send_word(lru_pl_pkg::CMD_INSERT, held_page[LIST_DEPTH / 2], 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_LOOKUP, held_page[0], 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_LOOKUP, held_page[LIST_DEPTH - 1], 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_PAGE, held_page[LIST_DEPTH - 1], 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_EVICT_PAGE, held_page[LIST_DEPTH / 3], 1'b0, 1'b0);
    send_word(lru_pl_pkg::CMD_INSERT, fresh_page(), 1'b0, 1'b1);
    send_word(lru_pl_pkg::CMD_INSERT, fresh_page(), 1'b1, 1'b0);
    send_word(lru_pl_pkg::CMD_INSERT, fresh_page(), 1'b1, 1'b0);
    while (held_count > 0) begin
      pg = held_page[$urandom_range(0, held_count - 1)];
      case ($urandom_range(0, 2))
        0: send_word(lru_pl_pkg::CMD_EVICT_LRU, $urandom, rand_bit(), rand_bit());
        1: send_word(lru_pl_pkg::CMD_EVICT_PAGE, pg, rand_bit(), rand_bit());
        default: send_word(lru_pl_pkg::CMD_LOOKUP, pg, rand_bit(), rand_bit());
      endcase
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_len = 200;
    hold_req = 1'b1;
    repeat (40)
      send_word(lru_pl_pkg::cmd_e'($urandom_range(0, 3)), pick_page(40), rand_bit(),
                rand_bit());
  endtask

  task automatic test_sender_pause();
    wait_drain();
    gaps_on = 1'b1;
    repeat (20)
      send_word(lru_pl_pkg::cmd_e'($urandom_range(0, 3)), pick_page(40), rand_bit(),
                rand_bit());
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned      phase_left;
    int unsigned      roll;
    bit               growing;
    lru_pl_pkg::cmd_e cmd;
    phase_left = 0;
    growing = 1'b0;
    repeat (n_items) begin
      if (phase_left == 0) begin
        growing = ~growing;
        phase_left = $urandom_range(100, 300);
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (growing)
        cmd = (roll < 55) ? lru_pl_pkg::CMD_INSERT : (roll < 75) ? lru_pl_pkg::CMD_LOOKUP :
              (roll < 87) ? lru_pl_pkg::CMD_EVICT_LRU : lru_pl_pkg::CMD_EVICT_PAGE;
      else
        cmd = (roll < 15) ? lru_pl_pkg::CMD_INSERT : (roll < 40) ? lru_pl_pkg::CMD_LOOKUP :
              (roll < 70) ? lru_pl_pkg::CMD_EVICT_LRU : lru_pl_pkg::CMD_EVICT_PAGE;
      send_word(cmd, pick_page((cmd == lru_pl_pkg::CMD_INSERT) ? 10 : 70), rand_bit(),
                rand_bit());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = lru_pl_pkg::CMD_LOOKUP;
    page = '0;
    ref_bit = 1'b0;
    dirty_in = 1'b0;
    gaps_on = 1'b0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_len = 0;
    error_count = 0;
    held_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_insert_lookup_edges();
    test_fill_to_capacity();
    test_backpressure();
    test_sender_pause();
    test_random_traffic(1000);
    in_valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
